FILE: rtl/indexed_list_shift_store_core_macros.svh
// Assertion macros shared by the list store RTL.
`ifndef INDEXED_LIST_SHIFT_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_SHIFT_STORE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ILSS_ASSERT(label, clk_s, rst_n_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
        else $error(msg);
// Check that a condition never holds outside reset.
`define ILSS_ASSERT_NEVER(label, clk_s, rst_n_s, cond, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) \
        else $error(msg);
`else
`define ILSS_ASSERT(label, clk_s, rst_n_s, prop, msg)
`define ILSS_ASSERT_NEVER(label, clk_s, rst_n_s, cond, msg)
`endif

`endif

FILE: rtl/ilss_pkg.sv
`timescale 1ns / 1ps

package ilss_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_MV,
        S_INS_PUT,
        S_REM_GET,
        S_REM_MV,
        S_RD_GET,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        SRC_HOLD,
        SRC_LOAD_TOP,
        SRC_LOAD_POS,
        SRC_DEC,
        SRC_INC
    } src_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_END,
        WR_UP,
        WR_DOWN,
        WR_POS
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        logic    in_ready;
        src_op_t src_op;
        wr_sel_t wr_sel;
        cnt_op_t cnt_op;
        logic    res_cap;
        logic    st_load;
        status_t st_val;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic                in_valid;
        logic [OPCODE_W-1:0] op;
        logic                full;
        logic                pos_oor;
        logic                src_eq_pos;
        logic                src_last;
        logic                out_free;
    } stat_t;

endpackage

FILE: rtl/ilss_in_if.sv
`timescale 1ns / 1ps

interface ilss_in_if;
    logic                          valid;
    logic                          ready;
    logic [ilss_pkg::OPCODE_W-1:0] opcode;
    logic [ilss_pkg::POS_W-1:0]    position;
    logic [ilss_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

FILE: rtl/ilss_out_if.sv
`timescale 1ns / 1ps

interface ilss_out_if;
    logic                          valid;
    logic                          ready;
    logic [ilss_pkg::VALUE_W-1:0]  read_value;
    logic [ilss_pkg::COUNT_W-1:0]  entry_count;
    logic [ilss_pkg::STATUS_W-1:0] status;

    modport source (output valid, output read_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input entry_count, input status,
                    output ready);
endinterface

FILE: rtl/ilss_ram.sv
`timescale 1ns / 1ps

module ilss_ram #(
    parameter int WIDTH = ilss_pkg::VALUE_W,
    parameter int DEPTH = ilss_pkg::DEF_CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ilss_ctrl.sv
`timescale 1ns / 1ps

module ilss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  ilss_pkg::stat_t  stat,
    output ilss_pkg::cmd_t   cmd
);

    ilss_pkg::state_t state_reg;
    ilss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilss_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.in_ready = 1'b0;
        cmd.src_op   = ilss_pkg::SRC_HOLD;
        cmd.wr_sel   = ilss_pkg::WR_NONE;
        cmd.cnt_op   = ilss_pkg::CNT_HOLD;
        cmd.res_cap  = 1'b0;
        cmd.st_load  = 1'b0;
        cmd.st_val   = ilss_pkg::ST_OK;
        cmd.out_load = 1'b0;

        unique case (state_reg)
            ilss_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = ilss_pkg::S_DECODE;
                end
            end

            ilss_pkg::S_DECODE:
            begin
                state_next = ilss_pkg::S_DONE;
                unique case (stat.op)
                    ilss_pkg::OP_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_val  = ilss_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_sel = ilss_pkg::WR_END;
                            cmd.cnt_op = ilss_pkg::CNT_INC;
                        end
                    end
                    ilss_pkg::OP_INSERT:
                    begin
                        priority if (stat.full)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_val  = ilss_pkg::ST_FULL;
                        end
                        else if (stat.pos_oor)
                        begin
                            cmd.wr_sel = ilss_pkg::WR_END;
                            cmd.cnt_op = ilss_pkg::CNT_INC;
                        end
                        else
                        begin
                            // start the upward shift at the last entry
                            cmd.src_op = ilss_pkg::SRC_LOAD_TOP;
                            state_next = ilss_pkg::S_INS_MV;
                        end
                    end
                    ilss_pkg::OP_REMOVE:
                    begin
                        if (stat.pos_oor)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_val  = ilss_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.src_op = ilss_pkg::SRC_LOAD_POS;
                            state_next = ilss_pkg::S_REM_GET;
                        end
                    end
                    ilss_pkg::OP_READ:
                    begin
                        if (stat.pos_oor)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_val  = ilss_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.src_op = ilss_pkg::SRC_LOAD_POS;
                            state_next = ilss_pkg::S_RD_GET;
                        end
                    end
                    ilss_pkg::OP_CLEAR:
                    begin
                        cmd.cnt_op = ilss_pkg::CNT_CLR;
                    end
                    default:
                    begin
                        // unused opcode: answer ok, change nothing
                    end
                endcase
            end

            ilss_pkg::S_INS_MV:
            begin
                cmd.wr_sel = ilss_pkg::WR_UP;
                if (stat.src_eq_pos)
                begin
                    state_next = ilss_pkg::S_INS_PUT;
                end
                else
                begin
                    cmd.src_op = ilss_pkg::SRC_DEC;
                end
            end

            ilss_pkg::S_INS_PUT:
            begin
                cmd.wr_sel = ilss_pkg::WR_POS;
                cmd.cnt_op = ilss_pkg::CNT_INC;
                state_next = ilss_pkg::S_DONE;
            end

            ilss_pkg::S_REM_GET:
            begin
                cmd.res_cap = 1'b1;
                if (stat.src_last)
                begin
                    cmd.cnt_op = ilss_pkg::CNT_DEC;
                    state_next = ilss_pkg::S_DONE;
                end
                else
                begin
                    cmd.src_op = ilss_pkg::SRC_INC;
                    state_next = ilss_pkg::S_REM_MV;
                end
            end

            ilss_pkg::S_REM_MV:
            begin
                cmd.wr_sel = ilss_pkg::WR_DOWN;
                if (stat.src_last)
                begin
                    cmd.cnt_op = ilss_pkg::CNT_DEC;
                    state_next = ilss_pkg::S_DONE;
                end
                else
                begin
                    cmd.src_op = ilss_pkg::SRC_INC;
                end
            end

            ilss_pkg::S_RD_GET:
            begin
                cmd.res_cap = 1'b1;
                state_next  = ilss_pkg::S_DONE;
            end

            ilss_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ilss_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ilss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ilss_dp.sv
`timescale 1ns / 1ps

module ilss_dp #(
    parameter int CAPACITY = ilss_pkg::DEF_CAPACITY
) (
    input  logic            clk,
    input  logic            rst_n,
    ilss_in_if.sink         req,
    ilss_out_if.source      rsp,
    input  ilss_pkg::cmd_t  cmd,
    output ilss_pkg::stat_t stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > ilss_pkg::COUNT_W) ? CW : ilss_pkg::COUNT_W;

    logic [ilss_pkg::OPCODE_W-1:0] op_reg;
    logic [ilss_pkg::POS_W-1:0]    pos_reg;
    logic [ilss_pkg::VALUE_W-1:0]  word_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [AW-1:0]                 src_reg;
    logic [AW-1:0]                 src_next;
    logic [ilss_pkg::VALUE_W-1:0]  result_reg;
    ilss_pkg::status_t             status_reg;

    logic                          out_valid_reg;
    logic [ilss_pkg::VALUE_W-1:0]  out_value_reg;
    logic [ilss_pkg::COUNT_W-1:0]  out_count_reg;
    ilss_pkg::status_t             out_status_reg;

    logic                          accept;
    logic [EW-1:0]                 count_ext;
    logic [EW-1:0]                 pos_ext;
    logic [EW-1:0]                 src_ext;
    logic [CW-1:0]                 count_m1;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [ilss_pkg::VALUE_W-1:0]  ram_wdata;
    logic [ilss_pkg::VALUE_W-1:0]  ram_rdata;

    assign req.ready = cmd.in_ready;
    assign accept    = req.valid && cmd.in_ready;

    assign count_ext = EW'(count_reg);
    assign pos_ext   = EW'(pos_reg);
    assign src_ext   = EW'(src_reg);
    assign count_m1  = count_reg - CW'(1);

    // read address follows the next pointer so the registered read data matches src_reg
    always_comb
    begin
        unique case (cmd.src_op)
            ilss_pkg::SRC_HOLD:     src_next = src_reg;
            ilss_pkg::SRC_LOAD_TOP: src_next = count_m1[AW-1:0];
            ilss_pkg::SRC_LOAD_POS: src_next = pos_ext[AW-1:0];
            ilss_pkg::SRC_DEC:      src_next = src_reg - AW'(1);
            ilss_pkg::SRC_INC:      src_next = src_reg + AW'(1);
            default:                src_next = src_reg;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = src_reg;
        ram_wdata = ram_rdata;
        unique case (cmd.wr_sel)
            ilss_pkg::WR_NONE:
            begin
                ram_we = 1'b0;
            end
            ilss_pkg::WR_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = word_reg;
            end
            ilss_pkg::WR_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = src_reg + AW'(1);
            end
            ilss_pkg::WR_DOWN:
            begin
                ram_we    = 1'b1;
                ram_waddr = src_reg - AW'(1);
            end
            ilss_pkg::WR_POS:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_ext[AW-1:0];
                ram_wdata = word_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.cnt_op)
            ilss_pkg::CNT_HOLD: count_next = count_reg;
            ilss_pkg::CNT_INC:  count_next = count_reg + CW'(1);
            ilss_pkg::CNT_DEC:  count_next = count_m1;
            ilss_pkg::CNT_CLR:  count_next = '0;
            default:            count_next = count_reg;
        endcase
    end

    ilss_ram #(
        .WIDTH (ilss_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (src_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        if (accept)
        begin
            op_reg     <= req.opcode;
            pos_reg    <= req.position;
            word_reg   <= req.value;
            result_reg <= '0;
            status_reg <= ilss_pkg::ST_OK;
        end
        else
        begin
            if (cmd.res_cap)
            begin
                result_reg <= ram_rdata;
            end
            if (cmd.st_load)
            begin
                status_reg <= cmd.st_val;
            end
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= result_reg;
            out_count_reg  <= count_ext[ilss_pkg::COUNT_W-1:0];
            out_status_reg <= status_reg;
        end
    end

    assign stat.in_valid   = req.valid;
    assign stat.op         = op_reg;
    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.pos_oor    = (pos_ext >= count_ext);
    assign stat.src_eq_pos = (src_ext == pos_ext);
    assign stat.src_last   = ((src_ext + EW'(1)) == count_ext);
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.status      = out_status_reg;

endmodule

FILE: rtl/indexed_list_shift_store_core.sv
`timescale 1ns / 1ps
// Channel   Role     Beat contents
// req       sink     opcode, position, value
// rsp       source   read_value, entry_count, status
//
// One item at a time: appends, inserts past the end, clears, refused and flagged items skip
// the shift; a read fetches entry p, an insert at p below count moves p..count-1 up, then
// writes p, and a remove takes entry p and moves the entries above it down, one per cycle
// through the single RAM write port; ready returns in the cycle after the rsp load.
// Reset clears count, rsp valid and state, not the entry words. A stalled rsp holds its
// beat while the next item is accepted and worked on; that item waits in its final state.

`include "indexed_list_shift_store_core_macros.svh"

module indexed_list_shift_store_core #(
    parameter int CAPACITY = ilss_pkg::DEF_CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    ilss_in_if.sink    req,
    ilss_out_if.source rsp
);

    // command and status bundles between sequencer and datapath
    ilss_pkg::cmd_t  cmd;
    ilss_pkg::stat_t stat;

    // terms watched by the checks below
    logic req_beat;
    logic grow_full;
    logic load_during_write;

    // sequencer: decode the held item, step the shift, hand off the result
    ilss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: item registers, entry count, shift pointer, entry RAM, rsp register
    ilss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign req_beat          = req.valid && req.ready;
    assign grow_full         = (cmd.cnt_op == ilss_pkg::CNT_INC) && stat.full;
    assign load_during_write = cmd.out_load && (cmd.wr_sel != ilss_pkg::WR_NONE);

    // after an accepted beat, drop ready until the item completes
    `ILSS_ASSERT(a_busy_after_accept, clk, rst_n, req_beat |=> !req.ready, "accepted while busy")
    // never grow a full list
    `ILSS_ASSERT_NEVER(a_no_grow_full, clk, rst_n, grow_full, "count grows past capacity")
    // never overwrite a waiting rsp beat
    `ILSS_ASSERT(a_load_when_free, clk, rst_n, cmd.out_load |-> stat.out_free, "beat overwritten")
    // hand off a result only after the memory work is over
    `ILSS_ASSERT_NEVER(a_load_no_write, clk, rst_n, load_during_write, "load during entry write")

endmodule
